// ===== rtl/uar_pkg.sv =====
// shared types and constants for the utf-8 astral replacer
// no dependencies
`timescale 1ns / 1ps

package uar_pkg;

	localparam logic [7:0] REPL_RESET   = 8'd86;

	// lead byte classification masks and patterns
	localparam logic [7:0] ASCII_MASK   = 8'h80;
	localparam logic [7:0] LEAD2_MASK   = 8'hE0;
	localparam logic [7:0] LEAD2_PAT    = 8'hC0;
	localparam logic [7:0] LEAD3_MASK   = 8'hF0;
	localparam logic [7:0] LEAD3_PAT    = 8'hE0;
	localparam logic [7:0] LEAD4_MASK   = 8'hF8;
	localparam logic [7:0] LEAD4_PAT    = 8'hF0;

	// bits that lift a 4-byte code point above the basic plane
	localparam logic [7:0] PLANE_LEAD_MASK = 8'h07;
	localparam logic [7:0] PLANE_CONT_MASK = 8'h30;

	// number of result words produced for one input word
	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	typedef struct packed {
		logic [1:0] count;
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       inv;
	} uar_res_t;

endpackage

// ===== rtl/uar_ifs.sv =====
// handshake interfaces for the text input, result output and config write
// depends on nothing
`timescale 1ns / 1ps

interface uar_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	modport source (output valid, output text_byte, input ready);
	modport sink   (input valid, input text_byte, output ready);
endinterface

interface uar_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] result_byte;
	logic       run_end;
	logic       invalid_lead_seen;
	modport source (output valid, output result_byte, output run_end,
		output invalid_lead_seen, input ready);
	modport sink   (input valid, input result_byte, input run_end,
		input invalid_lead_seen, output ready);
endinterface

interface uar_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] wdata;
	modport source (output valid, output wdata, input ready);
	modport sink   (input valid, input wdata, output ready);
endinterface

// ===== rtl/utf8_astral_replacer.sv =====
// top level of the utf-8 astral replacer: config register, decode, result buffer
// depends on uar_pkg, uar_ifs, uar_decode, uar_out_buf
`timescale 1ns / 1ps

// Byte-serial UTF-8 filter. One text word is taken per cycle whenever the
// result side keeps up; a word gives zero, one or two result words. A
// 4-byte lead is held back silently and its second byte then yields two
// words: the original pair, or the replacement byte twice when the code
// point lies above the basic plane (its last two bytes are then dropped).
// Throughput is one input word per cycle, limited only by the single
// result port: a two-word result stalls input while its first word drains.
// Result words are registered. The sticky invalid_lead_seen bit, carried
// with every result word, tells the host to throw the output away and
// keep the original text. The replacement register resets to 86 and may
// be written only while the block is idle.

module utf8_astral_replacer (
	input  logic         clk,
	input  logic         arst_n,
	uar_byte_if.sink     text,
	uar_result_if.source result,
	uar_cfg_if.sink      cfg
);

	logic [7:0]        repl_q;
	logic              take;
	logic              can_load;
	uar_pkg::uar_res_t res;

	// config write port never stalls
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repl_q <= uar_pkg::REPL_RESET;
		end else if (cfg.valid) begin
			repl_q <= cfg.wdata;
		end
	end

	// a word enters when the result buffer is empty or drains its last word
	assign text.ready = can_load;
	assign take       = text.valid && can_load;

	// sequence state and rewrite decision
	uar_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.text_byte (text.text_byte),
		.repl      (repl_q),
		.res       (res)
	);

	// result register, drains one word per handshake
	uar_out_buf u_out_buf (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (take),
		.res               (res),
		.can_load          (can_load),
		.out_valid         (result.valid),
		.out_ready         (result.ready),
		.result_byte       (result.result_byte),
		.run_end           (result.run_end),
		.invalid_lead_seen (result.invalid_lead_seen)
	);

endmodule

// ===== rtl/uar_decode.sv =====
// sequence tracking and rewrite decision for one input word
// depends on uar_pkg
`timescale 1ns / 1ps

module uar_decode (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [7:0]        text_byte,
	input  logic [7:0]        repl,
	output uar_pkg::uar_res_t res
);

	logic [1:0] remain_q;
	logic       drop_q;
	logic       hold_q;
	logic [7:0] lead_q;
	logic       inv_q;

	logic [1:0] remain_d;
	logic       drop_d;
	logic       hold_d;
	logic [7:0] lead_d;
	logic       inv_d;
	logic       astral;

	assign astral = ((lead_q & uar_pkg::PLANE_LEAD_MASK) != 8'h00)
		|| ((text_byte & uar_pkg::PLANE_CONT_MASK) != 8'h00);

	always_comb begin
		remain_d  = remain_q;
		drop_d    = drop_q;
		hold_d    = hold_q;
		lead_d    = lead_q;
		inv_d     = inv_q;
		res.count = uar_pkg::CNT_ONE;
		res.byte0 = text_byte;
		res.byte1 = text_byte;
		if (hold_q) begin
			// second byte of a 4-byte sequence decides
			hold_d    = 1'b0;
			remain_d  = 2'd2;
			res.count = uar_pkg::CNT_TWO;
			drop_d    = astral;
			if (astral) begin
				res.byte0 = repl;
				res.byte1 = repl;
			end else begin
				res.byte0 = lead_q;
				res.byte1 = text_byte;
			end
		end else if (remain_q != 2'd0) begin
			remain_d = remain_q - 2'd1;
			if (remain_q == 2'd1)
				drop_d = 1'b0;
			if (drop_q)
				res.count = uar_pkg::CNT_NONE;
		end else begin
			drop_d = 1'b0;
			priority if ((text_byte & uar_pkg::ASCII_MASK) == 8'h00) begin
				remain_d = 2'd0;
			end else if ((text_byte & uar_pkg::LEAD2_MASK) == uar_pkg::LEAD2_PAT) begin
				remain_d = 2'd1;
			end else if ((text_byte & uar_pkg::LEAD3_MASK) == uar_pkg::LEAD3_PAT) begin
				remain_d = 2'd2;
			end else if ((text_byte & uar_pkg::LEAD4_MASK) == uar_pkg::LEAD4_PAT) begin
				hold_d    = 1'b1;
				lead_d    = text_byte;
				res.count = uar_pkg::CNT_NONE;
			end else begin
				inv_d = 1'b1;
			end
		end
		res.inv = inv_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remain_q <= 2'd0;
			drop_q   <= 1'b0;
			hold_q   <= 1'b0;
			lead_q   <= 8'h00;
			inv_q    <= 1'b0;
		end else if (take) begin
			remain_q <= remain_d;
			drop_q   <= drop_d;
			hold_q   <= hold_d;
			lead_q   <= lead_d;
			inv_q    <= inv_d;
		end
	end

endmodule

// ===== rtl/uar_out_buf.sv =====
// two-word result register that drains one word per handshake
// depends on uar_pkg
`timescale 1ns / 1ps

module uar_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load,
	input  uar_pkg::uar_res_t res,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        result_byte,
	output logic              run_end,
	output logic              invalid_lead_seen
);

	logic [1:0] cnt_q;
	logic [7:0] first_q;
	logic [7:0] second_q;
	logic       inv_q;
	logic       pop;

	assign out_valid         = (cnt_q != uar_pkg::CNT_NONE);
	assign pop               = out_valid && out_ready;
	assign result_byte       = first_q;
	assign run_end           = (cnt_q == uar_pkg::CNT_ONE);
	assign invalid_lead_seen = inv_q;
	// free after this edge: empty, or the last word leaves now
	assign can_load = (cnt_q == uar_pkg::CNT_NONE)
		|| ((cnt_q == uar_pkg::CNT_ONE) && out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= uar_pkg::CNT_NONE;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			first_q  <= res.byte0;
			second_q <= res.byte1;
			inv_q    <= res.inv;
		end else if (pop) begin
			first_q <= second_q;
		end
	end

endmodule

// ===== test/uar_checker.sv =====
// checker for the utf-8 astral replacer: watches text, result and config channels,
// predicts every result word and compares; depends on uar_pkg and uar_ifs
`timescale 1ns / 1ps

module uar_checker (
	input  logic        clk,
	input  logic        arst_n,
	uar_byte_if         text,
	uar_result_if       result,
	uar_cfg_if          cfg,
	output int unsigned fail_count,
	output int unsigned pending
);

	typedef struct packed {
		logic [7:0] value;
		logic       last;
		logic       inv;
	} out_word_t;

	out_word_t  expected_words[$];

	// predicted block state
	logic [7:0] repl_byte;
	logic [7:0] held_lead;
	logic [1:0] cont_left;
	logic       drop_cont;
	logic       lead_held;
	logic       inv_sticky;

	task report(input string what, input logic [7:0] got, input logic [7:0] want);
		$display("%0t ns: mismatch on %s, got %02h expected %02h", $time, what, got, want);
		fail_count++;
	endtask

	task push_word(input logic [7:0] v, input logic last);
		out_word_t nw;
		nw.value = v;
		nw.last  = last;
		nw.inv   = inv_sticky;
		expected_words = {expected_words, nw};
	endtask

	// one accepted text word in, zero to two result words expected
	task predict_text(input logic [7:0] b);
		logic skip;
		logic silent;
		skip   = 1'b0;
		silent = 1'b0;
		if (lead_held) begin
			lead_held = 1'b0;
			cont_left = 2'd2;
			if ((held_lead & uar_pkg::PLANE_LEAD_MASK) != 8'd0
				|| (b & uar_pkg::PLANE_CONT_MASK) != 8'd0) begin
				drop_cont = 1'b1;
				push_word(repl_byte, 1'b0);
				push_word(repl_byte, 1'b1);
			end else begin
				drop_cont = 1'b0;
				push_word(held_lead, 1'b0);
				push_word(b, 1'b1);
			end
		end else if (cont_left != 2'd0) begin
			skip      = drop_cont;
			cont_left = cont_left - 2'd1;
			if (cont_left == 2'd0) begin
				drop_cont = 1'b0;
			end
			if (!skip) begin
				push_word(b, 1'b1);
			end
		end else begin
			if ((b & uar_pkg::ASCII_MASK) == 8'd0) begin
				// plain ascii
			end else if ((b & uar_pkg::LEAD2_MASK) == uar_pkg::LEAD2_PAT) begin
				cont_left = 2'd1;
			end else if ((b & uar_pkg::LEAD3_MASK) == uar_pkg::LEAD3_PAT) begin
				cont_left = 2'd2;
			end else if ((b & uar_pkg::LEAD4_MASK) == uar_pkg::LEAD4_PAT) begin
				lead_held = 1'b1;
				held_lead = b;
				silent    = 1'b1;
			end else begin
				inv_sticky = 1'b1;
			end
			if (!silent) begin
				drop_cont = 1'b0;
				push_word(b, 1'b1);
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_word_t w;
		if (!arst_n) begin
			repl_byte  = uar_pkg::REPL_RESET;
			held_lead  = 8'd0;
			cont_left  = 2'd0;
			drop_cont  = 1'b0;
			lead_held  = 1'b0;
			inv_sticky = 1'b0;
			fail_count = 0;
			expected_words.delete();
			pending <= 0;
		end else begin
			if (result.valid && result.ready) begin
				if (expected_words.size() == 0) begin
					report("unexpected result word", result.result_byte, 8'h00);
				end else begin
					w = expected_words.pop_front();
					if (result.result_byte !== w.value) begin
						report("result_byte", result.result_byte, w.value);
					end
					if (result.run_end !== w.last) begin
						report("run_end", {7'd0, result.run_end}, {7'd0, w.last});
					end
					if (result.invalid_lead_seen !== w.inv) begin
						report("invalid_lead_seen", {7'd0, result.invalid_lead_seen},
							{7'd0, w.inv});
					end
				end
			end
			if (cfg.valid && cfg.ready) begin
				repl_byte = cfg.wdata;
			end
			if (text.valid && text.ready) begin
				predict_text(text.text_byte);
			end
			pending <= expected_words.size();
		end
	end

endmodule

// ===== test/tb_utf8_astral_replacer.sv =====
// testbench top for the utf-8 astral replacer: clock, reset, stimulus, verdict
// depends on uar_pkg, uar_ifs, utf8_astral_replacer and uar_checker
`timescale 1ns / 1ps

module tb_utf8_astral_replacer;

	// cycles with no word moving on any channel before the run is declared hung
	localparam int unsigned HANG_LIMIT = 2000;
	// words of random text per configuration phase
	localparam int unsigned PHASE_WORDS = 125;
	// cycles allowed after the last result for anything still in flight
	localparam int unsigned SETTLE_CYCLES = 4;

	logic        clk    = 1'b0;
	logic        arst_n = 1'b0;
	logic        idle_on = 1'b1;
	int unsigned fail_count;
	int unsigned pending;
	int unsigned quiet_cycles = 0;

	// directed text: ascii extremes, 2 and 3 byte sequences (the bom among
	// them), a 4-byte sequence that stays in the basic plane, an astral one,
	// an astral one whose second byte is zero and whose dropped bytes look
	// like ascii and a lead, and finally the invalid leads at both ends of both ranges
	logic [7:0] directed_text[$] = '{
		8'h00, 8'h7F,
		8'hC2, 8'hA9,
		8'hEF, 8'hBB, 8'hBF,
		8'hF0, 8'h8F, 8'hBF, 8'hBF,
		8'hF0, 8'h9F, 8'h98, 8'h80,
		8'hF7, 8'h00, 8'h41, 8'hC3,
		8'h80, 8'hBF, 8'hF8, 8'hFF
	};

	uar_byte_if   text_ch ();
	uar_result_if result_ch ();
	uar_cfg_if    cfg_ch ();

	utf8_astral_replacer uut (
		.clk    (clk),
		.arst_n (arst_n),
		.text   (text_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	uar_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text_ch),
		.result     (result_ch),
		.cfg        (cfg_ch),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always #6 clk = ~clk;

	// result side back-pressure: drops ready about 23 percent of the time,
	// never while idling is switched off
	always @(posedge clk) begin
		result_ch.ready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
	end

	// hang detection: any moved word restarts the count
	always @(posedge clk) begin
		if (arst_n) begin
			if ((text_ch.valid && text_ch.ready) || (result_ch.valid && result_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= HANG_LIMIT) begin
				$display("tb_utf8_astral_replacer: errors");
				$finish;
			end
		end
	end

	// offer one text word, with random gaps ahead of it while idling is on;
	// returns in the step of the accepting edge with valid still high
	task send_text(input logic [7:0] b);
		while (idle_on && $urandom_range(99) < 23) begin
			text_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_ch.valid     <= 1'b1;
		text_ch.text_byte <= b;
		do @(posedge clk); while (!text_ch.ready);
	endtask

	// stop sending and hold off until every expected word has come back,
	// then let the block settle in case a silently held lead is still in it
	task drain_results;
		text_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// replacement register write, only ever issued after drain_results
	task write_replacement(input logic [7:0] v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.wdata <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic logic [7:0] cont_byte();
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	// random text: mostly well-formed sequences with random content,
	// the rest raw noise that breaks sequences and hits invalid leads
	task send_random_text(input int unsigned words);
		int unsigned sent;
		int unsigned pick;
		logic [7:0]  lead;
		logic [7:0]  second;
		sent = 0;
		while (sent < words) begin
			pick = $urandom_range(99);
			if (pick < 20) begin
				send_text(8'($urandom_range(255)));
				sent += 1;
			end else if (pick < 40) begin
				send_text(8'($urandom_range(127)));
				sent += 1;
			end else if (pick < 55) begin
				send_text(8'hC0 | 8'($urandom_range(31)));
				send_text(cont_byte());
				sent += 2;
			end else if (pick < 70) begin
				send_text(8'hE0 | 8'($urandom_range(15)));
				send_text(cont_byte());
				send_text(cont_byte());
				sent += 3;
			end else begin
				// about half of the 4-byte sequences stay in the basic plane
				if ($urandom_range(1) == 0) begin
					lead   = 8'hF0;
					second = 8'h80 | 8'($urandom_range(15));
				end else begin
					lead   = 8'hF0 | 8'($urandom_range(7));
					second = cont_byte();
				end
				send_text(lead);
				send_text(second);
				send_text(cont_byte());
				send_text(cont_byte());
				sent += 4;
			end
		end
	endtask

	initial begin
		logic [7:0] repl;
		// every text and config input known from time zero
		text_ch.valid     <= 1'b0;
		text_ch.text_byte <= 8'h00;
		cfg_ch.valid      <= 1'b0;
		cfg_ch.wdata      <= 8'h00;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed text under the reset replacement byte
		foreach (directed_text[i]) begin
			send_text(directed_text[i]);
		end
		drain_results();

		// phases: both extremes of the replacement byte, then random ones;
		// the third phase runs with no idling on either side
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: repl = 8'h00;
				1: repl = 8'hFF;
				default: repl = 8'($urandom_range(255));
			endcase
			write_replacement(repl);
			idle_on = (p != 2);
			send_random_text(PHASE_WORDS);
			drain_results();
		end

		if (fail_count == 0) begin
			$display("tb_utf8_astral_replacer: clean");
		end else begin
			$display("tb_utf8_astral_replacer: errors");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/uar_pkg.sv
rtl/uar_ifs.sv
rtl/uar_decode.sv
rtl/uar_out_buf.sv
rtl/utf8_astral_replacer.sv
test/uar_checker.sv
test/tb_utf8_astral_replacer.sv
